>>> hw/rtl/vlrr_pkg.sv
// shared types and codes for the variable-length record ring
package vlrr_pkg;

    localparam int CW_W  = 18;
    localparam int CLEN_W = 16;

    localparam logic [1:0] ACT_RESERVE = 2'd0;
    localparam logic [1:0] ACT_PUBLISH = 2'd1;
    localparam logic [1:0] ACT_POP     = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_REJECTED = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_BUSY     = 2'd3;

    localparam logic [1:0] CW_NONE    = 2'd0;
    localparam logic [1:0] CW_WRITING = 2'd1;
    localparam logic [1:0] CW_READY   = 2'd2;
    localparam logic [1:0] CW_PAD     = 2'd3;

    localparam logic [12:0] MAX_ENTRY_RESET = 13'd1024;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PAD,
        S_CHK
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [11:0] offset;
        logic [12:0] entry_length;
        logic [31:0] overflow_count;
    } t_result;

endpackage

>>> hw/rtl/vlrr_ram.sv
// generic simple dual-port ram with registered read
module vlrr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/vlrr_ctrl.sv
// sequencer and pointer logic for reserve, publish and pop
module vlrr_ctrl #(
    parameter int RING_BYTES   = 4096,
    parameter int HEADER_BYTES = 32,
    parameter int IDX_W        = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_action,
    input  logic [12:0]          i_length,
    input  logic [11:0]          i_entry_offset,
    input  logic                 i_skip_busy,
    input  logic [12:0]          i_max_entry_bytes,
    output logic                 o_busy,
    output logic                 o_mem_we,
    output logic [IDX_W-1:0]     o_mem_waddr,
    output logic [17:0]          o_mem_wdata,
    output logic [IDX_W-1:0]     o_mem_raddr,
    input  logic [17:0]          i_mem_rdata,
    output vlrr_pkg::t_result    o_result
);
    import vlrr_pkg::*;

    localparam int RING_WORDS = RING_BYTES / 4;
    localparam int RW = ((IDX_W + 1) > 14 ? (IDX_W + 1) : 14) + 1;
    localparam int PW = (IDX_W > 10 ? IDX_W : 10) + 1;

    t_state r_state, n_state;

    logic [1:0]       r_action;
    logic [12:0]      r_length;
    logic [11:0]      r_eoff;
    logic             r_skip;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [31:0]      r_count, n_count;
    t_result          r_res, n_res;

    logic [RW-1:0]    words_x, head_x, tail_x, used_x, free_x, contig_x;
    logic [13:0]      req_sum, total_b;
    logic [RW-1:0]    total_x, head_adv;
    logic [IDX_W-1:0] head_lin;
    logic             too_big, fits_here, room_here, room_wrap, pad_case;
    logic [1:0]       rd_st;
    logic [15:0]      rd_len;
    logic [RW-1:0]    len_x, tail_adv;
    logic [IDX_W-1:0] tail_lin;
    logic             bad, skip_case;
    logic [PW-1:0]    pub_x;
    logic             pub_ok;

    assign words_x  = RW'(RING_WORDS);
    assign head_x   = RW'(r_head);
    assign tail_x   = RW'(r_tail);
    assign used_x   = (r_head >= r_tail) ? head_x - tail_x : head_x + words_x - tail_x;
    assign free_x   = words_x - used_x - RW'(1);
    assign contig_x = words_x - head_x;

    assign req_sum   = {1'b0, r_length} + 14'd3;
    assign total_b   = {req_sum[13:2], 2'b00};
    assign total_x   = RW'(req_sum[13:2]);
    assign too_big   = total_b > {1'b0, i_max_entry_bytes};
    assign fits_here = contig_x >= total_x;
    assign room_here = total_x <= free_x;
    assign room_wrap = (contig_x + total_x) <= free_x;
    assign pad_case  = !too_big && !fits_here && room_wrap;
    assign head_adv  = head_x + total_x;
    assign head_lin  = (head_adv == words_x) ? '0 : IDX_W'(head_adv);

    assign rd_st    = i_mem_rdata[17:16];
    assign rd_len   = i_mem_rdata[15:0];
    assign len_x    = RW'(rd_len[15:2]);
    assign tail_adv = tail_x + len_x;
    assign tail_lin = (tail_adv == words_x) ? '0 : IDX_W'(tail_adv);
    assign bad = (rd_len < 16'd4) || (rd_len[1:0] != 2'b00) || (tail_adv > words_x) ||
                 (len_x > used_x) || (rd_st == CW_NONE) ||
                 ((rd_st == CW_READY) && (rd_len <= 16'(HEADER_BYTES)));
    assign skip_case = !bad && ((rd_st == CW_PAD) || ((rd_st == CW_WRITING) && r_skip));

    assign pub_x  = PW'(r_eoff[11:2]);
    assign pub_ok = pub_x < PW'(RING_WORDS);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_action == ACT_RESERVE && pad_case) begin
                    n_state = S_PAD;
                end else if (r_action == ACT_POP && r_head != r_tail) begin
                    n_state = S_CHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                n_state = S_IDLE;
            end
            S_CHK: begin
                n_state = skip_case ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory writes
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_res       = r_res;
        n_res.valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_head;
        o_mem_wdata = '0;
        case (r_state)
            S_EXEC: begin
                case (r_action)
                    ACT_RESERVE: begin
                        if (!too_big && fits_here && room_here) begin
                            o_mem_we     = 1'b1;
                            o_mem_wdata  = {CW_WRITING, CLEN_W'(total_b)};
                            n_head       = head_lin;
                            n_res.valid  = 1'b1;
                            n_res.status = STAT_OK;
                            n_res.offset = 12'({r_head, 2'b00});
                            n_res.entry_length = 13'(total_b);
                        end else if (pad_case) begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = {CW_PAD, CLEN_W'({contig_x, 2'b00})};
                        end else begin
                            n_count      = r_count + 32'd1;
                            n_res.valid  = 1'b1;
                            n_res.status = STAT_REJECTED;
                            n_res.offset = '0;
                            n_res.entry_length = '0;
                        end
                    end
                    ACT_PUBLISH: begin
                        o_mem_we     = pub_ok;
                        o_mem_waddr  = IDX_W'(pub_x);
                        o_mem_wdata  = {CW_READY, CLEN_W'(r_length)};
                        n_res.valid  = 1'b1;
                        n_res.status = STAT_OK;
                        n_res.offset = r_eoff;
                        n_res.entry_length = r_length;
                    end
                    ACT_POP: begin
                        if (r_head == r_tail) begin
                            n_res.valid  = 1'b1;
                            n_res.status = STAT_EMPTY;
                            n_res.offset = '0;
                            n_res.entry_length = '0;
                        end
                    end
                    default: begin
                        n_res.valid  = 1'b1;
                        n_res.status = STAT_OK;
                        n_res.offset = '0;
                        n_res.entry_length = '0;
                    end
                endcase
            end
            S_PAD: begin
                o_mem_we     = 1'b1;
                o_mem_waddr  = '0;
                o_mem_wdata  = {CW_WRITING, CLEN_W'(total_b)};
                n_head       = IDX_W'(total_x);
                n_res.valid  = 1'b1;
                n_res.status = STAT_OK;
                n_res.offset = '0;
                n_res.entry_length = 13'(total_b);
            end
            S_CHK: begin
                if (bad) begin
                    n_tail       = r_head;
                    n_count      = r_count + 32'd1;
                    n_res.valid  = 1'b1;
                    n_res.status = STAT_EMPTY;
                    n_res.offset = '0;
                    n_res.entry_length = '0;
                end else if (rd_st == CW_WRITING && !r_skip) begin
                    n_res.valid  = 1'b1;
                    n_res.status = STAT_BUSY;
                    n_res.offset = 12'({r_tail, 2'b00});
                    n_res.entry_length = 13'(rd_len);
                end else if (rd_st == CW_READY) begin
                    n_tail       = tail_lin;
                    n_res.valid  = 1'b1;
                    n_res.status = STAT_OK;
                    n_res.offset = 12'({r_tail, 2'b00});
                    n_res.entry_length = 13'(rd_len);
                end else begin
                    n_tail = tail_lin;
                end
            end
            default: begin
                n_res.valid = 1'b0;
            end
        endcase
        if (n_res.valid) begin
            n_res.overflow_count = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_action <= i_action;
            r_length <= i_length;
            r_eoff   <= i_entry_offset;
            r_skip   <= i_skip_busy;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_mem_raddr = r_tail;
    assign o_result    = r_res;

endmodule

>>> hw/rtl/variable_length_record_ring.sv
// top level of the variable-length record ring control-word manager
//
// Commands enter on start with action, length, entry_offset and skip_busy and
// are taken at a rising edge with start high and busy low. Each command gives
// exactly one result word, shown for one cycle with o_valid high; the receiver
// cannot stall, so nothing is held back on the output side.
// Sequence from the accepting edge to the result word, which is registered:
//   reserve, publish, empty pop, unused action: execute state, then the result
//   reserve that places a pad record first: execute (pad write), then pad state
//   pop: execute, then check, repeated for every pad or skipped busy record
// This is set by the control-word ram: one write port, so a padded
// reserve writes twice, and a registered read for each word popped.
// A new command can be accepted in the same cycle as the previous result.
// Users write max entry size register with i_cfg_we only while idle; unchecked.
// Reset (synchronous, active low) clears head, tail and the overflow count and
// sets max entry size to 1024; control words are not cleared and need none.
module variable_length_record_ring #(
    parameter int RING_BYTES   = 4096,
    parameter int HEADER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [12:0] i_length,
    input  logic [11:0] i_entry_offset,
    input  logic        i_skip_busy,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [11:0] o_offset,
    output logic [12:0] o_entry_length,
    output logic [31:0] o_overflow_count
);
    import vlrr_pkg::*;

    localparam int RING_WORDS = RING_BYTES / 4;
    localparam int IDX_W      = $clog2(RING_WORDS);

    logic [12:0]      r_max_entry_bytes;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [CW_W-1:0]  mem_wdata, mem_rdata;
    t_result          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entry_bytes <= MAX_ENTRY_RESET;
        end else if (i_cfg_we) begin
            r_max_entry_bytes <= i_cfg_wdata;
        end
    end

    vlrr_ram #(
        .WIDTH (CW_W),
        .DEPTH (RING_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    vlrr_ctrl #(
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_action          (i_action),
        .i_length          (i_length),
        .i_entry_offset    (i_entry_offset),
        .i_skip_busy       (i_skip_busy),
        .i_max_entry_bytes (r_max_entry_bytes),
        .o_busy            (busy),
        .o_mem_we          (mem_we),
        .o_mem_waddr       (mem_waddr),
        .o_mem_wdata       (mem_wdata),
        .o_mem_raddr       (mem_raddr),
        .i_mem_rdata       (mem_rdata),
        .o_result          (result)
    );

    assign o_valid          = result.valid;
    assign o_status         = result.status;
    assign o_offset         = result.offset;
    assign o_entry_length   = result.entry_length;
    assign o_overflow_count = result.overflow_count;

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a command in progress");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_no_data_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_EMPTY || o_status == STAT_REJECTED)) |->
        (o_offset == 12'd0 && o_entry_length == 13'd0))
        else $error("empty or rejected result carries a record");

endmodule
